@@ rtl/hill_cipher_2x2_mod26_macros.svh @@
`ifndef HILL_CIPHER_2X2_MOD26_MACROS_SVH
`define HILL_CIPHER_2X2_MOD26_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define HC2_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define HC2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hc2_pkg.sv @@
package hc2_pkg;

    localparam logic [4:0] ALPHA = 5'd26;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TOP_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TOP_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BOTTOM_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BOTTOM_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE     = 3'd4;

    localparam logic [4:0] KEY_TOP_LEFT_RST     = 5'd9;
    localparam logic [4:0] KEY_TOP_RIGHT_RST    = 5'd4;
    localparam logic [4:0] KEY_BOTTOM_LEFT_RST  = 5'd5;
    localparam logic [4:0] KEY_BOTTOM_RIGHT_RST = 5'd7;

    typedef struct packed {
        logic [4:0] letter_in;
        logic       message_end;
    } t_in;

    typedef struct packed {
        logic [4:0] letter_out;
        logic       pair_end;
        logic       key_error;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_INV,
        S_MAT,
        S_SUM,
        S_RED,
        S_OUT_FIRST,
        S_OUT_SECOND
    } t_state;

    typedef struct packed {
        logic hold;
        logic load_pair;
        logic pair_has_held;
        logic do_prod;
        logic do_inv;
        logic do_mat;
        logic do_sum;
        logic do_red;
        logic sel_second;
    } t_dp_cmd;

    function automatic logic [4:0] mod26_5(input logic [4:0] v);
        return (v >= ALPHA) ? 5'(v - ALPHA) : v;
    endfunction

    function automatic logic [4:0] mod26_6(input logic [5:0] v);
        logic [5:0] r;
        r = (v >= 6'(ALPHA)) ? 6'(v - 6'(ALPHA)) : v;
        return r[4:0];
    endfunction

    // reciprocal multiply, quotient low by at most one, then one correction
    function automatic logic [4:0] mod26_11(input logic [10:0] v);
        logic [23:0] prod;
        logic [6:0]  q;
        logic [11:0] r;
        prod = 24'(v) * 24'd5041;
        q    = prod[23:17];
        r    = {1'b0, v} - 12'(12'(q) * 12'(ALPHA));
        if (r >= 12'(ALPHA)) begin
            r = 12'(r - 12'(ALPHA));
        end
        return r[4:0];
    endfunction

    function automatic logic [4:0] inv_mod26(input logic [4:0] v);
        logic [4:0] r;
        case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/hc2_datapath.sv @@
module hc2_datapath import hc2_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [4:0]           i_cfg_wdata,
    input  t_in                  i_in_data,
    input  t_dp_cmd              i_cmd,
    output t_out                 o_out_data
);

    logic [4:0] r_key_tl, r_key_tr, r_key_bl, r_key_br;
    logic       r_decrypt;

    logic [4:0] r_held;
    logic [4:0] r_p1, r_p2;
    logic [4:0] r_a, r_b, r_c, r_d;
    logic       r_dec;
    logic [4:0] r_ad, r_bc;
    logic [4:0] r_inv;
    logic       r_err;
    logic [4:0] r_m00, r_m01, r_m10, r_m11;
    logic [10:0] r_s1, r_s2;
    logic [4:0] r_r1, r_r2;

    logic [4:0] n_p1, n_p2;
    logic [4:0] n_det, n_inv;
    logic [4:0] n_nb, n_nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_tl  <= KEY_TOP_LEFT_RST;
            r_key_tr  <= KEY_TOP_RIGHT_RST;
            r_key_bl  <= KEY_BOTTOM_LEFT_RST;
            r_key_br  <= KEY_BOTTOM_RIGHT_RST;
            r_decrypt <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY_TOP_LEFT:     r_key_tl  <= i_cfg_wdata;
                CFG_KEY_TOP_RIGHT:    r_key_tr  <= i_cfg_wdata;
                CFG_KEY_BOTTOM_LEFT:  r_key_bl  <= i_cfg_wdata;
                CFG_KEY_BOTTOM_RIGHT: r_key_br  <= i_cfg_wdata;
                CFG_DECRYPT_MODE:     r_decrypt <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_p1 = i_cmd.pair_has_held ? r_held : i_in_data.letter_in;
        n_p2 = i_cmd.pair_has_held ? i_in_data.letter_in : 5'd0;
        n_det = mod26_6(6'(r_ad) + 6'(ALPHA) - 6'(r_bc));
        n_inv = inv_mod26(n_det);
        n_nb  = (r_b == 5'd0) ? 5'd0 : 5'(ALPHA - r_b);
        n_nc  = (r_c == 5'd0) ? 5'd0 : 5'(ALPHA - r_c);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            r_held <= i_in_data.letter_in;
        end
        if (i_cmd.load_pair) begin
            r_p1  <= mod26_5(n_p1);
            r_p2  <= mod26_5(n_p2);
            r_a   <= mod26_5(r_key_tl);
            r_b   <= mod26_5(r_key_tr);
            r_c   <= mod26_5(r_key_bl);
            r_d   <= mod26_5(r_key_br);
            r_dec <= r_decrypt;
        end
        if (i_cmd.do_prod) begin
            r_ad <= mod26_11(11'(10'(r_a) * 10'(r_d)));
            r_bc <= mod26_11(11'(10'(r_b) * 10'(r_c)));
        end
        if (i_cmd.do_inv) begin
            r_inv <= n_inv;
            r_err <= r_dec && (n_inv == 5'd0);
        end
        if (i_cmd.do_mat) begin
            if (r_dec) begin
                r_m00 <= mod26_11(11'(10'(r_d) * 10'(r_inv)));
                r_m01 <= mod26_11(11'(10'(n_nb) * 10'(r_inv)));
                r_m10 <= mod26_11(11'(10'(n_nc) * 10'(r_inv)));
                r_m11 <= mod26_11(11'(10'(r_a) * 10'(r_inv)));
            end else begin
                r_m00 <= r_a;
                r_m01 <= r_b;
                r_m10 <= r_c;
                r_m11 <= r_d;
            end
        end
        if (i_cmd.do_sum) begin
            r_s1 <= 11'(10'(r_m00) * 10'(r_p1)) + 11'(10'(r_m01) * 10'(r_p2));
            r_s2 <= 11'(10'(r_m10) * 10'(r_p1)) + 11'(10'(r_m11) * 10'(r_p2));
        end
        if (i_cmd.do_red) begin
            r_r1 <= r_err ? 5'd0 : mod26_11(r_s1);
            r_r2 <= r_err ? 5'd0 : mod26_11(r_s2);
        end
    end

    always_comb begin
        o_out_data.letter_out = i_cmd.sel_second ? r_r2 : r_r1;
        o_out_data.pair_end   = i_cmd.sel_second;
        o_out_data.key_error  = r_err;
    end

endmodule

@@ rtl/hc2_ctrl.sv @@
`include "hill_cipher_2x2_mod26_macros.svh"

module hc2_ctrl import hc2_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_holding, n_holding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_holding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_holding <= n_holding;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_holding = r_holding;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_holding || i_in_last) begin
                        n_state   = S_PROD;
                        n_holding = 1'b0;
                    end else begin
                        n_holding = 1'b1;
                    end
                end
            end
            S_PROD:  n_state = S_INV;
            S_INV:   n_state = S_MAT;
            S_MAT:   n_state = S_SUM;
            S_SUM:   n_state = S_RED;
            S_RED:   n_state = S_OUT_FIRST;
            S_OUT_FIRST: begin
                if (!i_out_stall) begin
                    n_state = S_OUT_SECOND;
                end
            end
            S_OUT_SECOND: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;
        o_cmd.pair_has_held = r_holding;
        case (r_state)
            S_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.hold      = i_in_valid && !r_holding && !i_in_last;
                o_cmd.load_pair = i_in_valid && (r_holding || i_in_last);
            end
            S_PROD:  o_cmd.do_prod = 1'b1;
            S_INV:   o_cmd.do_inv  = 1'b1;
            S_MAT:   o_cmd.do_mat  = 1'b1;
            S_SUM:   o_cmd.do_sum  = 1'b1;
            S_RED:   o_cmd.do_red  = 1'b1;
            S_OUT_FIRST: begin
                o_out_valid = 1'b1;
            end
            S_OUT_SECOND: begin
                o_out_valid      = 1'b1;
                o_cmd.sel_second = 1'b1;
            end
            default: ;
        endcase
    end

    `HC2_ASSERT_NOW(a_no_input_while_output, o_out_valid, o_in_stall,
                    "input open while result pending")
    `HC2_ASSERT_NEXT(a_first_letter_held,
                     i_in_valid && !o_in_stall && !r_holding && !i_in_last,
                     r_holding && (r_state == S_IDLE), "opening letter not held")
    `HC2_ASSERT_NEXT(a_pair_done_clears, (r_state == S_OUT_SECOND) && !i_out_stall,
                     (r_state == S_IDLE) && !r_holding, "pair end not followed by idle")

endmodule

@@ rtl/hill_cipher_2x2_mod26.sv @@
// 2x2 Hill cipher over letter codes 0..25. Letters are paired; each completed pair is
// multiplied by the key matrix (encrypt) or by its inverse mod 26 (decrypt) and yields two
// transactions, the second with pair_end set. A final odd letter is padded with 0. When
// decrypting with a key whose determinant has no inverse mod 26, both results carry
// key_error and letter 0. Timing: a letter that opens a pair is taken and the input stays
// open; the letter that completes a pair is followed by the compute states of the
// controller sequence (key products, determinant inverse, matrix, sums, reduction),
// during which input is stalled, then the two results are offered one per cycle unless
// the output stalls. Keys and mode are sampled when a pair completes; write
// configuration only while idle.
module hill_cipher_2x2_mod26 import hc2_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [4:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data
);

    t_dp_cmd cmd;

    hc2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.message_end),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    hc2_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_out_data  (o_out_data)
    );

endmodule

@@ verif/hill_cipher_2x2_mod26_tb.sv @@
module hill_cipher_2x2_mod26_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hc2_pkg::*;

    localparam int ITEM_TARGET    = 1700;
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int DRAIN_PAUSE    = 12;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int N_ROWS         = 39;

    typedef struct packed {
        logic                 cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [4:0]           val;
        logic                 eom;
        logic                 typed;
        logic [4:0]           exp1;
        logic [4:0]           exp2;
        logic                 err;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [4:0]           i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;

    logic [4:0] key_reg [4];
    logic       dec_mode;
    logic [4:0] held_code;
    logic       have_held;
    t_out       cipher_q [$];

    int  fails = 0;
    int  letters_sent = 0;
    int  results_seen = 0;
    int  err_seen = 0;
    int  cfg_writes = 0;
    int  cycles = 0;
    bit  squeeze_req = 1'b0;

    t_row directed_rows [N_ROWS] = '{
        '{1'b0, '0, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd0,  1'b0, 1'b1, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd25, 1'b1, 1'b1, 5'd17, 5'd21, 1'b0},
        '{1'b0, '0, 5'd31, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd31, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd1,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd0,  1'b0, 1'b1, 5'd9,  5'd5,  1'b0},
        '{1'b1, CFG_DECRYPT_MODE, 5'd1, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b0, '0, 5'd3,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd7,  1'b1, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd26, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd10, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b1, CFG_KEY_TOP_LEFT,     5'd2, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, CFG_KEY_TOP_RIGHT,    5'd4, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, CFG_KEY_BOTTOM_LEFT,  5'd1, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, CFG_KEY_BOTTOM_RIGHT, 5'd2, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b0, '0, 5'd5,  1'b0, 1'b1, 5'd0,  5'd0,  1'b1},
        '{1'b0, '0, 5'd31, 1'b1, 1'b1, 5'd0,  5'd0,  1'b1},
        '{1'b1, CFG_DECRYPT_MODE, 5'd0, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b0, '0, 5'd1,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd1,  1'b0, 1'b1, 5'd6,  5'd3,  1'b0},
        '{1'b1, CFG_KEY_TOP_LEFT,     5'd31, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, CFG_KEY_TOP_RIGHT,    5'd31, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, CFG_KEY_BOTTOM_LEFT,  5'd31, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, CFG_KEY_BOTTOM_RIGHT, 5'd31, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, 3'(CFG_DECRYPT_MODE + 1), 5'd0,  1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, 3'(CFG_DECRYPT_MODE + 2), 5'd31, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, 3'(CFG_DECRYPT_MODE + 3), 5'd13, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b0, '0, 5'd31, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd31, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b1, CFG_KEY_TOP_LEFT,  5'd0,  1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, CFG_KEY_TOP_RIGHT, 5'd25, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b1, CFG_DECRYPT_MODE,  5'd31, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b0, '0, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd25, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd12, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b1, CFG_DECRYPT_MODE,  5'd30, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0},
        '{1'b0, '0, 5'd13, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
        '{1'b0, '0, 5'd24, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0}
    };

    hill_cipher_2x2_mod26 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int recip26(input int v);
        for (int x = 1; x < 26; x++) begin
            if ((v * x) % 26 == 1) begin
                return x;
            end
        end
        return 0;
    endfunction

    // returns the number of letters the transaction releases
    function automatic int hill_step(input t_in item, output t_out first, output t_out second);
        int p1, p2, a, b, c, d, det, inv, m00, m01, m10, m11;
        first  = '0;
        second = '0;
        second.pair_end = 1'b1;
        if (!have_held && !item.message_end) begin
            held_code = item.letter_in;
            have_held = 1'b1;
            return 0;
        end
        if (have_held) begin
            p1 = int'(held_code) % 26;
            p2 = int'(item.letter_in) % 26;
        end else begin
            p1 = int'(item.letter_in) % 26;
            p2 = 0;
        end
        have_held = 1'b0;
        held_code = '0;
        a = int'(key_reg[CFG_KEY_TOP_LEFT[1:0]]) % 26;
        b = int'(key_reg[CFG_KEY_TOP_RIGHT[1:0]]) % 26;
        c = int'(key_reg[CFG_KEY_BOTTOM_LEFT[1:0]]) % 26;
        d = int'(key_reg[CFG_KEY_BOTTOM_RIGHT[1:0]]) % 26;
        m00 = a;
        m01 = b;
        m10 = c;
        m11 = d;
        if (dec_mode) begin
            det = (a * d - b * c + 676) % 26;
            inv = recip26(det);
            if (inv == 0) begin
                first.key_error  = 1'b1;
                second.key_error = 1'b1;
                return 2;
            end
            m00 = (d * inv) % 26;
            m01 = ((26 - b) * inv) % 26;
            m10 = ((26 - c) * inv) % 26;
            m11 = (a * inv) % 26;
        end
        first.letter_out  = 5'((m00 * p1 + m01 * p2) % 26);
        second.letter_out = 5'((m10 * p1 + m11 * p2) % 26);
        return 2;
    endfunction

    function automatic int pick_gap(input bit eager);
        int r;
        r = $urandom_range(0, 99);
        if (eager || r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [4:0] pick_key();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            return 5'd0;
        end
        if (r < 4) begin
            return 5'd25;
        end
        if (r == 4) begin
            return 5'($urandom_range(26, 31));
        end
        return 5'($urandom_range(1, 24));
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_KEY_TOP_LEFT, CFG_KEY_TOP_RIGHT,
            CFG_KEY_BOTTOM_LEFT, CFG_KEY_BOTTOM_RIGHT: key_reg[idx[1:0]] = val;
            CFG_DECRYPT_MODE: dec_mode = val[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // drop valid, wait for every letter to come back, then let the block settle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (cipher_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_letter(input logic [4:0] code, input logic last_flag,
                               output t_out first, output t_out second, output int n);
        t_in item;
        item.letter_in   = code;
        item.message_end = last_flag;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        n = hill_step(item, first, second);
        letters_sent++;
    endtask

    initial begin
        t_out first_res, second_res;
        int n, quota, msg_len, phase;
        bit in_cfg, eager, noise;
        logic [4:0] code;
        logic last_flag;
        logic [CFG_IDX_W-1:0] idx;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        key_reg[CFG_KEY_TOP_LEFT[1:0]]     = KEY_TOP_LEFT_RST;
        key_reg[CFG_KEY_TOP_RIGHT[1:0]]    = KEY_TOP_RIGHT_RST;
        key_reg[CFG_KEY_BOTTOM_LEFT[1:0]]  = KEY_BOTTOM_LEFT_RST;
        key_reg[CFG_KEY_BOTTOM_RIGHT[1:0]] = KEY_BOTTOM_RIGHT_RST;
        dec_mode  = 1'b0;
        held_code = '0;
        have_held = 1'b0;
        in_cfg    = 1'b0;
        phase     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg) begin
                if (!in_cfg) begin
                    settle();
                    in_cfg = 1'b1;
                end
                cfg_write(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                if (in_cfg) begin
                    i_cfg_wr_en <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_letter(directed_rows[i].val, directed_rows[i].eom,
                            first_res, second_res, n);
                if (directed_rows[i].typed) begin
                    cipher_q.push_back('{directed_rows[i].exp1, 1'b0, directed_rows[i].err});
                    cipher_q.push_back('{directed_rows[i].exp2, 1'b1, directed_rows[i].err});
                end else if (n == 2) begin
                    cipher_q.push_back(first_res);
                    cipher_q.push_back(second_res);
                end
                pause_sender(pick_gap(1'b0));
            end
        end

        while (letters_sent < ITEM_TARGET) begin
            phase++;
            settle();
            for (idx = CFG_KEY_TOP_LEFT; idx <= CFG_KEY_BOTTOM_RIGHT; idx++) begin
                if ($urandom_range(0, 1) == 1) begin
                    cfg_write(idx, pick_key());
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                cfg_write(CFG_DECRYPT_MODE, 5'($urandom_range(0, 31)));
            end
            if ($urandom_range(0, 7) == 0) begin
                cfg_write(3'(CFG_DECRYPT_MODE + $urandom_range(1, 3)), 5'($urandom_range(0, 31)));
            end
            i_cfg_wr_en <= 1'b0;
            if (phase == 2 || phase == 9) begin
                squeeze_req = 1'b1;
            end
            eager = ($urandom_range(0, 4) == 0);
            quota = $urandom_range(30, 90);
            while (quota > 0 && letters_sent < ITEM_TARGET) begin
                msg_len = $urandom_range(1, 12);
                noise   = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < msg_len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        code = 5'($urandom_range(26, 31));
                    end else begin
                        code = 5'($urandom_range(0, 25));
                    end
                    if (noise) begin
                        last_flag = ($urandom_range(0, 3) == 0);
                    end else begin
                        last_flag = (k == msg_len - 1);
                    end
                    send_letter(code, last_flag, first_res, second_res, n);
                    if (n == 2) begin
                        cipher_q.push_back(first_res);
                        cipher_q.push_back(second_res);
                    end
                    pause_sender(pick_gap(eager));
                    quota--;
                end
            end
        end

        settle();
        $display("covered %0d letters over %0d random key settings and %0d register writes",
                 letters_sent, phase, cfg_writes);
        $display("checked %0d output letters, %0d of them flagged with a key error",
                 results_seen, err_seen);
        if (fails == 0) begin
            $display("hill_cipher_2x2_mod26_tb OK");
        end else begin
            $display("hill_cipher_2x2_mod26_tb NOT OK");
        end
        $finish;
    end

    // receiver: short and long hold-offs, quiet stretches, and the long squeeze on request
    initial begin
        int run;
        i_out_stall = 1'b0;
        forever begin
            if (squeeze_req) begin
                i_out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                squeeze_req = 1'b0;
            end else begin
                i_out_stall <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 8);
                do begin
                    @(posedge i_clk);
                    run--;
                end while (run > 0 && !squeeze_req);
                if (!squeeze_req) begin
                    i_out_stall <= 1'b1;
                    run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(1, 3);
                    do begin
                        @(posedge i_clk);
                        run--;
                    end while (run > 0 && !squeeze_req);
                end
            end
        end
    end

    initial begin
        t_out want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (cipher_q.size() == 0) begin
                    $error("unexpected transaction: letter_out %0d pair_end %0b key_error %0b",
                           o_out_data.letter_out, o_out_data.pair_end, o_out_data.key_error);
                    fails++;
                end else begin
                    want = cipher_q.pop_front();
                    results_seen++;
                    if (want.key_error) begin
                        err_seen++;
                    end
                    if (o_out_data.letter_out !== want.letter_out) begin
                        $error("letter_out: expected %0d, got %0d",
                               want.letter_out, o_out_data.letter_out);
                        fails++;
                    end
                    if (o_out_data.pair_end !== want.pair_end) begin
                        $error("pair_end: expected %0b, got %0b",
                               want.pair_end, o_out_data.pair_end);
                        fails++;
                    end
                    if (o_out_data.key_error !== want.key_error) begin
                        $error("key_error: expected %0b, got %0b",
                               want.key_error, o_out_data.key_error);
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d letters still owed", cycles, cipher_q.size());
            $display("hill_cipher_2x2_mod26_tb NOT OK");
            $finish;
        end
    end

endmodule
